[rtl/cwc_pkg.sv]
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and codes for the configurable word cache.
// ----------------------------------------------------------------------------
package cwc_pkg;

  localparam int unsigned WordW = 16;

  typedef enum logic [1:0] {
    ORG_FULL   = 2'd0,
    ORG_DIRECT = 2'd1,
    ORG_SET    = 2'd2,
    ORG_NONE   = 2'd3
  } org_e;

  typedef enum logic [0:0] {
    WP_BACK    = 1'b0,
    WP_THROUGH = 1'b1
  } wpol_e;

  localparam logic [0:0] RegOrg = 1'b0;
  localparam logic [0:0] RegWpol = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [WordW-1:0] address;
    logic             mode;
    logic             is_byte;
    logic [WordW-1:0] data_word;
    logic [WordW-1:0] memory_word;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [WordW-1:0] read_data;
    logic             evict_valid;
    logic [WordW-1:0] evict_address;
    logic [WordW-1:0] evict_data;
    logic             through_valid;
    logic [WordW-1:0] through_address;
    logic [WordW-1:0] through_data;
    logic [WordW-1:0] hit_count;
    logic [WordW-1:0] access_count;
  } rsp_t;

  typedef struct packed {
    logic [0:0]       index;
    logic [WordW-1:0] data;
  } cfg_t;

endpackage

[rtl/cwc_if.sv]
// ----------------------------------------------------------------------------
// cwc_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface cwc_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/configurable_word_cache_unit.sv]
// ----------------------------------------------------------------------------
// configurable_word_cache_unit
// One-word-per-line cache: direct mapped, fully or set associative with LRU, or uncached.
// ----------------------------------------------------------------------------
// Channels: req (sink) carries one access word: address, mode, is_byte,
// data_word and the backing memory_word for a fill. rsp (source) returns
// one result word per access: hit, read data, any dirty eviction, any
// write-through write and the running hit and access counts.
// cfg (sink) writes organization (index 0) or write_policy (index 1);
// write it only while the cache is idle. Other indexes are dropped.
// Flow: an accepted word is captured, then looked up with its line updated
// across the searched group in the LOOK state, and its result is loaded
// into an output register; taking it frees the input in the same cycle,
// so a new word is taken only as the previous result leaves.
// Stall: while the receiver holds off, the result holds and no new word
// is taken.
// Reset: all lines invalid, ages and counters zero, organization set
// associative, write-back.
// ----------------------------------------------------------------------------
module configurable_word_cache_unit import cwc_pkg::*; #(
  parameter int unsigned LINES = 16,
  parameter int unsigned WAYS  = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  cwc_if.sink   req,
  cwc_if.source rsp,
  cwc_if.sink   cfg
);

  org_e  org_q;
  wpol_e wpol_q;
  cmd_t  cmd;
  cfg_t  cfg_w;

  assign cfg_w     = cfg.data;
  assign cfg.ready = 1'b1;

  // hold configuration; drop writes to indexes past the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q  <= ORG_SET;
      wpol_q <= WP_BACK;
    end else if (cfg.valid) begin
      unique case (cfg_w.index)
        RegOrg:  org_q  <= org_e'(cfg_w.data[1:0]);
        RegWpol: wpol_q <= wpol_e'(cfg_w.data[0]);
        default: ;
      endcase
    end
  end

  cwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  cwc_dpath #(.LINES(LINES), .WAYS(WAYS)) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req.data),
    .org_i  (org_q),
    .wpol_i (wpol_q),
    .rsp_o  (rsp.data)
  );

endmodule

[rtl/cwc_ctrl.sv]
// ----------------------------------------------------------------------------
// cwc_ctrl
// Sequencer: capture word, look up and update, hold result for the sink.
// ----------------------------------------------------------------------------
module cwc_ctrl import cwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.update   = 1'b1;
        cmd_o.out_load = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          // take the next word straight away
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d = ST_LOOK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/cwc_dpath.sv]
// ----------------------------------------------------------------------------
// cwc_dpath
// Line arrays, lookup, victim choice, LRU ages and counters.
// ----------------------------------------------------------------------------
module cwc_dpath import cwc_pkg::*; #(
  parameter int unsigned LINES = 16,
  parameter int unsigned WAYS  = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  req_t  req_i,
  input  org_e  org_i,
  input  wpol_e wpol_i,
  output rsp_t  rsp_o
);

  localparam int unsigned SETS = LINES / WAYS;
  localparam int unsigned IdxW = $clog2(LINES);
  localparam int unsigned SetW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned AgeW = $clog2(LINES);

  req_t             req_q;
  logic [WordW-1:0] tag_q  [LINES];
  logic [WordW-1:0] data_q [LINES];
  logic [AgeW-1:0]  age_q  [LINES];
  logic [LINES-1:0] valid_q, dirty_q;
  logic [WordW-1:0] hcnt_q, acnt_q;
  rsp_t             rsp_q;

  // group membership and search
  logic [LINES-1:0] grp, hitv, invv, age0v;
  logic [IdxW-1:0]  first;
  logic [AgeW-1:0]  top_age;
  logic [WordW-2:0] waddr;
  logic [WordW-1:0] tag;
  logic             hit, found_inv, found_age0;
  logic [IdxW-1:0]  idx, hit_idx, inv_idx, age0_idx;

  assign waddr = req_q.address[WordW-1:1];
  assign tag   = {req_q.address[WordW-1:1], 1'b0};

  always_comb begin
    logic [IdxW-1:0] set_first;
    set_first = '0;
    if (SETS > 1) begin
      set_first = IdxW'(waddr[SetW-1:0] * WAYS);
    end
    first   = '0;
    top_age = '0;
    grp     = '0;
    unique case (org_i)
      ORG_FULL: begin
        grp     = '1;
        top_age = AgeW'(LINES - 1);
      end
      ORG_DIRECT: begin
        first = waddr[IdxW-1:0];
        grp[first] = 1'b1;
      end
      ORG_SET: begin
        first   = set_first;
        top_age = AgeW'(WAYS - 1);
        for (int i = 0; i < LINES; i++) begin
          grp[i] = (IdxW'(i) >= set_first) && ((i - int'(set_first)) < WAYS);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      hitv[i]  = grp[i] && valid_q[i] && (tag_q[i] == tag);
      invv[i]  = grp[i] && !valid_q[i];
      age0v[i] = grp[i] && (age_q[i] == '0);
    end
    hit = 1'b0; found_inv = 1'b0; found_age0 = 1'b0;
    hit_idx = '0; inv_idx = '0; age0_idx = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (hitv[i])  begin hit = 1'b1;        hit_idx  = IdxW'(i); end
      if (invv[i])  begin found_inv = 1'b1;  inv_idx  = IdxW'(i); end
      if (age0v[i]) begin found_age0 = 1'b1; age0_idx = IdxW'(i); end
    end
    if (hit) idx = hit_idx;
    else if (found_inv) idx = inv_idx;
    else if (found_age0 && org_i != ORG_DIRECT) idx = age0_idx;
    else idx = first;
  end

  // access on the selected line
  logic [WordW-1:0] line_base, line_new, mask, result;
  logic             ev, use_age;
  assign line_base = hit ? data_q[idx] : req_q.memory_word;
  assign mask      = req_q.address[0] ? 16'hFF00 : 16'h00FF;
  assign ev        = !hit && !found_inv && valid_q[idx] && dirty_q[idx];
  assign use_age   = (org_i != ORG_DIRECT);

  always_comb begin
    line_new = line_base;
    result   = req_q.data_word;
    if (!req_q.mode) begin
      result = req_q.is_byte ? ((req_q.data_word & ~mask) | (line_base & mask)) : line_base;
    end else begin
      line_new = req_q.is_byte ? ((line_base & ~mask) | (req_q.data_word & mask))
                               : req_q.data_word;
    end
  end

  logic active;
  assign active = cmd_i.update && (org_i != ORG_NONE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (active) begin
      tag_q[idx]  <= tag;
      data_q[idx] <= line_new;
    end
    if (cmd_i.out_load) begin
      rsp_q.hit             <= active && hit;
      rsp_q.read_data       <= active ? result : req_q.data_word;
      rsp_q.evict_valid     <= active && ev;
      rsp_q.evict_address   <= (active && ev) ? tag_q[idx] : '0;
      rsp_q.evict_data      <= (active && ev) ? data_q[idx] : '0;
      rsp_q.through_valid   <= active && req_q.mode && wpol_i == WP_THROUGH;
      rsp_q.through_address <= (active && req_q.mode && wpol_i == WP_THROUGH) ? tag : '0;
      rsp_q.through_data    <= (active && req_q.mode && wpol_i == WP_THROUGH) ? line_new : '0;
      rsp_q.hit_count       <= (active && hit) ? hcnt_q + 1'b1 : hcnt_q;
      rsp_q.access_count    <= active ? acnt_q + 1'b1 : acnt_q;
    end
  end

  // line flags, ages and counters clear on reset; ages start at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      hcnt_q  <= '0;
      acnt_q  <= '0;
      for (int i = 0; i < LINES; i++) begin
        age_q[i] <= '0;
      end
    end else if (active) begin
      valid_q[idx] <= 1'b1;
      if (req_q.mode && wpol_i == WP_BACK) dirty_q[idx] <= 1'b1;
      else if (!hit) dirty_q[idx] <= 1'b0;
      if (hit) hcnt_q <= hcnt_q + 1'b1;
      acnt_q <= acnt_q + 1'b1;
      if (use_age) begin
        for (int i = 0; i < LINES; i++) begin
          if (grp[i] && age_q[i] > age_q[idx]) age_q[i] <= age_q[i] - 1'b1;
        end
        age_q[idx] <= top_age;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

[rtl/cwc_checker.sv]
// ----------------------------------------------------------------------------
// cwc_checker
// Port-level checks on the cache's request and response channels.
// ----------------------------------------------------------------------------
module cwc_checker import cwc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_no_take_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("word taken while result stalled");

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !rsp_valid ##1 rsp_valid)
    else $error("result not two cycles after accept");

  a_hit_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.hit |-> rsp_data.hit_count != '0)
    else $error("hit with zero hit count");

endmodule

bind configurable_word_cache_unit cwc_checker u_cwc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
